### rtl/core/gdfw_pkg.sv
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared sizes, codes and the result word type of the graph walker.
// ----------------------------------------------------------------------------
package gdfw_pkg;

  localparam int VERTEX_COUNT = 64;
  localparam int EDGE_SLOTS   = 256;

  localparam int VTX_W   = 6;
  localparam int VIDX_W  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int DEPTH_W = $clog2(VERTEX_COUNT + 1);
  localparam int SLOT_W  = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int EDGE_W  = $clog2(EDGE_SLOTS + 1);

  localparam logic [EDGE_W-1:0] NULL_EDGE = EDGE_W'(EDGE_SLOTS);

  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_WALK  = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_VISIT   = 3'd0,
    KIND_ADDED   = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_CLEARED = 3'd3,
    KIND_RANGE   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } res_t;

endpackage

### rtl/core/gdfw_ram.sv
// ----------------------------------------------------------------------------
// gdfw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gdfw_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/gdfw_out_reg.sv
// ----------------------------------------------------------------------------
// gdfw_out_reg
// Output word register that decouples the walker from the result stream.
// ----------------------------------------------------------------------------
module gdfw_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  gdfw_pkg::res_t                      res,
  output logic                                free,
  output logic                                tvalid,
  input  logic                                tready,
  output logic [gdfw_pkg::OUT_DATA_W-1:0]     tdata,  // vertex, zero pad
  output logic [gdfw_pkg::KIND_W-1:0]         tuser,  // kind
  output logic                                tlast
);

  gdfw_pkg::res_t held;

  assign free  = !tvalid || tready;
  assign tdata = {{(gdfw_pkg::OUT_DATA_W - gdfw_pkg::VTX_W){1'b0}}, held.vertex};
  assign tuser = held.kind;
  assign tlast = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (free) begin
      tvalid <= push;
    end
    if (free && push) begin
      held <= res;
    end
  end

endmodule

### rtl/core/graph_depth_first_walk.sv
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// Undirected adjacency-list graph store with a depth-first walk.
// ----------------------------------------------------------------------------
// One item is taken at a time. A clear and a rejected item go straight to
// their result word, and an add-edge first writes its two list entries. A
// walk reaches each vertex, scans list entries and backtracks, and waits
// whenever the result stream stalls; its pace is set by the single read port
// of the edge pool and walk stack memories, whose reads are registered. Head
// and visited marks are cleared at once by flops, so no clearing pass follows
// reset or a clear.
module graph_depth_first_walk (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gdfw_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // first_vertex, second_vertex
  input  logic [gdfw_pkg::OP_W-1:0]          s_axis_tuser,  // operation
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gdfw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // vertex
  output logic [gdfw_pkg::KIND_W-1:0]        m_axis_tuser,  // kind
  output logic                               m_axis_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_A,
    S_ADD_B,
    S_WALK_HEAD,
    S_WALK_LOOP,
    S_WALK_EDGE,
    S_WALK_POP,
    S_FINAL
  } state_t;

  state_t                             state;
  logic [gdfw_pkg::VTX_W-1:0]         reg_a;
  logic [gdfw_pkg::VTX_W-1:0]         reg_b;
  logic [gdfw_pkg::EDGE_W-1:0]        fill;
  logic [gdfw_pkg::EDGE_W-1:0]        cur;
  logic [gdfw_pkg::DEPTH_W-1:0]       dep;
  logic [gdfw_pkg::VTX_W-1:0]         pend;
  gdfw_pkg::kind_t                    fin_kind;
  logic [gdfw_pkg::VERTEX_COUNT-1:0]  hv;
  logic [gdfw_pkg::VERTEX_COUNT-1:0]  visited;
  logic                               hv_q;

  logic [gdfw_pkg::VTX_W-1:0]         in_a;
  logic [gdfw_pkg::VTX_W-1:0]         in_b;
  logic                               s_accept;
  logic                               in_a_ok;
  logic                               in_b_ok;
  logic [gdfw_pkg::EDGE_W-1:0]        fill_p1;
  logic [gdfw_pkg::DEPTH_W-1:0]       dep_m1;
  logic [gdfw_pkg::DEPTH_W-1:0]       dep_m2;

  logic                               head_we;
  logic [gdfw_pkg::VIDX_W-1:0]        head_waddr;
  logic [gdfw_pkg::EDGE_W-1:0]        head_wdata;
  logic                               head_re;
  logic [gdfw_pkg::VIDX_W-1:0]        head_raddr;
  logic [gdfw_pkg::EDGE_W-1:0]        head_rdata;
  logic [gdfw_pkg::EDGE_W-1:0]        head_val;

  logic                               edge_we;
  logic [gdfw_pkg::SLOT_W-1:0]        edge_waddr;
  logic [gdfw_pkg::VTX_W+gdfw_pkg::EDGE_W-1:0] edge_wdata;
  logic                               edge_re;
  logic [gdfw_pkg::SLOT_W-1:0]        edge_raddr;
  logic [gdfw_pkg::VTX_W+gdfw_pkg::EDGE_W-1:0] edge_rdata;
  logic [gdfw_pkg::VTX_W-1:0]         nb;
  logic [gdfw_pkg::EDGE_W-1:0]        nb_next;

  logic                               stack_we;
  logic [gdfw_pkg::VIDX_W-1:0]        stack_waddr;
  logic                               stack_re;
  logic [gdfw_pkg::VIDX_W-1:0]        stack_raddr;
  logic [gdfw_pkg::EDGE_W-1:0]        stack_rdata;

  logic                               push;
  gdfw_pkg::res_t                     res;
  logic                               free;

  assign in_a     = s_axis_tdata[gdfw_pkg::VTX_W-1:0];
  assign in_b     = s_axis_tdata[2*gdfw_pkg::VTX_W-1:gdfw_pkg::VTX_W];
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign in_a_ok  = (gdfw_pkg::VTX_W+1)'(in_a) < (gdfw_pkg::VTX_W+1)'(gdfw_pkg::VERTEX_COUNT);
  assign in_b_ok  = (gdfw_pkg::VTX_W+1)'(in_b) < (gdfw_pkg::VTX_W+1)'(gdfw_pkg::VERTEX_COUNT);
  assign fill_p1  = fill + gdfw_pkg::EDGE_W'(1);
  assign dep_m1   = dep - gdfw_pkg::DEPTH_W'(1);
  assign dep_m2   = dep - gdfw_pkg::DEPTH_W'(2);
  assign head_val = hv_q ? head_rdata : gdfw_pkg::NULL_EDGE;
  assign nb       = edge_rdata[gdfw_pkg::VTX_W+gdfw_pkg::EDGE_W-1:gdfw_pkg::EDGE_W];
  assign nb_next  = edge_rdata[gdfw_pkg::EDGE_W-1:0];
  assign s_axis_tready = (state == S_IDLE);

  gdfw_ram #(.DEPTH(gdfw_pkg::VERTEX_COUNT), .WIDTH(gdfw_pkg::EDGE_W)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
  );

  gdfw_ram #(.DEPTH(gdfw_pkg::EDGE_SLOTS), .WIDTH(gdfw_pkg::VTX_W + gdfw_pkg::EDGE_W)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
  );

  gdfw_ram #(.DEPTH(gdfw_pkg::VERTEX_COUNT), .WIDTH(gdfw_pkg::EDGE_W)) u_stack (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(nb_next),
    .re(stack_re), .raddr(stack_raddr), .rdata(stack_rdata)
  );

  gdfw_out_reg u_out (
    .clk(clk), .rst(rst), .push(push), .res(res), .free(free),
    .tvalid(m_axis_tvalid), .tready(m_axis_tready), .tdata(m_axis_tdata),
    .tuser(m_axis_tuser), .tlast(m_axis_tlast)
  );

  always_comb begin
    head_we     = 1'b0;
    head_waddr  = reg_a[gdfw_pkg::VIDX_W-1:0];
    head_wdata  = fill;
    head_re     = 1'b0;
    head_raddr  = in_a[gdfw_pkg::VIDX_W-1:0];
    edge_we     = 1'b0;
    edge_waddr  = fill[gdfw_pkg::SLOT_W-1:0];
    edge_wdata  = {reg_b, head_val};
    edge_re     = 1'b0;
    edge_raddr  = cur[gdfw_pkg::SLOT_W-1:0];
    stack_we    = 1'b0;
    stack_waddr = dep_m1[gdfw_pkg::VIDX_W-1:0];
    stack_re    = 1'b0;
    stack_raddr = dep_m2[gdfw_pkg::VIDX_W-1:0];
    push        = 1'b0;
    res.kind    = gdfw_pkg::KIND_VISIT;
    res.vertex  = pend;
    res.last    = 1'b0;
    unique case (state)
      S_IDLE: begin
        head_re = s_accept;
      end
      S_ADD_A: begin
        edge_we    = 1'b1;
        head_we    = 1'b1;
        head_re    = 1'b1;
        head_raddr = reg_b[gdfw_pkg::VIDX_W-1:0];
      end
      S_ADD_B: begin
        edge_we    = 1'b1;
        edge_waddr = fill_p1[gdfw_pkg::SLOT_W-1:0];
        // self loop: second entry follows the one just written
        edge_wdata = {reg_a, (reg_a == reg_b) ? fill : head_val};
        head_we    = 1'b1;
        head_waddr = reg_b[gdfw_pkg::VIDX_W-1:0];
        head_wdata = fill_p1;
      end
      S_WALK_HEAD: begin
      end
      S_WALK_LOOP: begin
        if (cur == gdfw_pkg::NULL_EDGE) begin
          stack_re = (dep != gdfw_pkg::DEPTH_W'(1));
        end else begin
          edge_re = 1'b1;
        end
      end
      S_WALK_EDGE: begin
        if (!visited[nb[gdfw_pkg::VIDX_W-1:0]] && free) begin
          push       = 1'b1;
          stack_we   = 1'b1;
          head_re    = 1'b1;
          head_raddr = nb[gdfw_pkg::VIDX_W-1:0];
        end
      end
      S_WALK_POP: begin
      end
      S_FINAL: begin
        push     = free;
        res.kind = fin_kind;
        res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      hv      <= '0;
      visited <= '0;
      fill    <= '0;
      dep     <= '0;
    end else begin
      if (head_we) begin
        hv[head_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            reg_a <= in_a;
            reg_b <= in_b;
            pend  <= '0;
            case (s_axis_tuser)
              gdfw_pkg::OP_CLEAR: begin
                hv       <= '0;
                visited  <= '0;
                fill     <= '0;
                fin_kind <= gdfw_pkg::KIND_CLEARED;
                state    <= S_FINAL;
              end
              gdfw_pkg::OP_ADD: begin
                if (!in_a_ok || !in_b_ok) begin
                  fin_kind <= gdfw_pkg::KIND_RANGE;
                  state    <= S_FINAL;
                end else if (fill > gdfw_pkg::EDGE_W'(gdfw_pkg::EDGE_SLOTS - 2)) begin
                  fin_kind <= gdfw_pkg::KIND_FULL;
                  state    <= S_FINAL;
                end else begin
                  state <= S_ADD_A;
                end
              end
              gdfw_pkg::OP_WALK: begin
                if (!in_a_ok) begin
                  fin_kind <= gdfw_pkg::KIND_RANGE;
                  state    <= S_FINAL;
                end else begin
                  visited[in_a[gdfw_pkg::VIDX_W-1:0]] <= 1'b1;
                  pend  <= in_a;
                  dep   <= gdfw_pkg::DEPTH_W'(1);
                  state <= S_WALK_HEAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_A: begin
          state <= S_ADD_B;
        end
        S_ADD_B: begin
          fill     <= fill + gdfw_pkg::EDGE_W'(2);
          fin_kind <= gdfw_pkg::KIND_ADDED;
          state    <= S_FINAL;
        end
        S_WALK_HEAD: begin
          cur   <= head_val;
          state <= S_WALK_LOOP;
        end
        S_WALK_LOOP: begin
          if (cur == gdfw_pkg::NULL_EDGE) begin
            if (dep == gdfw_pkg::DEPTH_W'(1)) begin
              fin_kind <= gdfw_pkg::KIND_VISIT;
              state    <= S_FINAL;
            end else begin
              state <= S_WALK_POP;
            end
          end else begin
            state <= S_WALK_EDGE;
          end
        end
        S_WALK_EDGE: begin
          if (visited[nb[gdfw_pkg::VIDX_W-1:0]]) begin
            cur   <= nb_next;
            state <= S_WALK_LOOP;
          end else if (free) begin
            visited[nb[gdfw_pkg::VIDX_W-1:0]] <= 1'b1;
            pend  <= nb;
            dep   <= dep + gdfw_pkg::DEPTH_W'(1);
            state <= S_WALK_HEAD;
          end
        end
        S_WALK_POP: begin
          cur   <= stack_rdata;
          dep   <= dep_m1;
          state <= S_WALK_LOOP;
        end
        S_FINAL: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (head_re) begin
      hv_q <= hv[head_raddr];
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    dep <= gdfw_pkg::DEPTH_W'(gdfw_pkg::VERTEX_COUNT))
    else $error("walk stack depth beyond vertex count");

  a_fill_even: assert property (@(posedge clk) disable iff (rst)
    !fill[0] && fill <= gdfw_pkg::EDGE_W'(gdfw_pkg::EDGE_SLOTS))
    else $error("edge pool fill count corrupt");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> free)
    else $error("result pushed into a busy output register");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_axis_tuser == gdfw_pkg::OP_CLEAR) |=>
      (hv == '0 && visited == '0 && fill == '0))
    else $error("clear left graph state behind");
`endif

endmodule

### tb/graph_depth_first_walk_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_depth_first_walk_tb
// Self-checking bench for the graph store and depth-first walker. A shadow
// copy of the adjacency lists and visited marks predicts every result word
// for each accepted command. Results are compared in order against the
// predicted words. Directed commands cover edge cases, a dense build fills the
// edge pool, and random builds and walks follow, with stalls on both streams.
// ----------------------------------------------------------------------------

class graph_shadow;
  logic [gdfw_pkg::EDGE_W-1:0] heads [gdfw_pkg::VERTEX_COUNT];
  logic [gdfw_pkg::VTX_W-1:0]  targets [gdfw_pkg::EDGE_SLOTS];
  logic [gdfw_pkg::EDGE_W-1:0] links [gdfw_pkg::EDGE_SLOTS];
  bit                          seen [gdfw_pkg::VERTEX_COUNT];
  int                          fill;
  gdfw_pkg::res_t              due_words [$];
  int                          failures;

  function void wipe();
    for (int i = 0; i < gdfw_pkg::VERTEX_COUNT; i++) begin
      heads[i] = gdfw_pkg::NULL_EDGE;
      seen[i]  = 1'b0;
    end
    fill = 0;
  endfunction

  function void push_word(gdfw_pkg::kind_t k, logic [gdfw_pkg::VTX_W-1:0] v, logic l);
    gdfw_pkg::res_t w;
    w.kind   = k;
    w.vertex = v;
    w.last   = l;
    due_words.push_back(w);
  endfunction

  function void walk_from(logic [gdfw_pkg::VTX_W-1:0] start);
    logic [gdfw_pkg::EDGE_W-1:0] path_cur [gdfw_pkg::VERTEX_COUNT];
    logic [gdfw_pkg::EDGE_W-1:0] cur;
    logic [gdfw_pkg::VTX_W-1:0]  nb;
    int depth;
    int reached;
    gdfw_pkg::res_t w;
    seen[start] = 1'b1;
    push_word(gdfw_pkg::KIND_VISIT, start, 1'b0);
    reached     = 1;
    path_cur[0] = heads[start];
    depth       = 1;
    while (depth > 0) begin
      cur = path_cur[depth-1];
      if (cur >= gdfw_pkg::NULL_EDGE) begin
        depth--;
      end else begin
        nb = targets[cur];
        path_cur[depth-1] = links[cur];
        if (!seen[nb] && reached < gdfw_pkg::VERTEX_COUNT &&
            depth < gdfw_pkg::VERTEX_COUNT) begin
          seen[nb] = 1'b1;
          push_word(gdfw_pkg::KIND_VISIT, nb, 1'b0);
          reached++;
          path_cur[depth] = heads[nb];
          depth++;
        end
      end
    end
    w = due_words.pop_back();
    w.last = 1'b1;
    due_words.push_back(w);
  endfunction

  function void note_item(logic [gdfw_pkg::OP_W-1:0] op, logic [gdfw_pkg::VTX_W-1:0] a,
                          logic [gdfw_pkg::VTX_W-1:0] b);
    case (op)
      gdfw_pkg::OP_CLEAR: begin
        wipe();
        push_word(gdfw_pkg::KIND_CLEARED, '0, 1'b1);
      end
      gdfw_pkg::OP_ADD: begin
        if (int'(a) >= gdfw_pkg::VERTEX_COUNT || int'(b) >= gdfw_pkg::VERTEX_COUNT) begin
          push_word(gdfw_pkg::KIND_RANGE, '0, 1'b1);
        end else if (fill > gdfw_pkg::EDGE_SLOTS - 2) begin
          push_word(gdfw_pkg::KIND_FULL, '0, 1'b1);
        end else begin
          targets[fill]     = b;
          links[fill]       = heads[a];
          heads[a]          = gdfw_pkg::EDGE_W'(fill);
          targets[fill + 1] = a;
          links[fill + 1]   = heads[b];
          heads[b]          = gdfw_pkg::EDGE_W'(fill + 1);
          fill += 2;
          push_word(gdfw_pkg::KIND_ADDED, '0, 1'b1);
        end
      end
      gdfw_pkg::OP_WALK: begin
        if (int'(a) >= gdfw_pkg::VERTEX_COUNT) push_word(gdfw_pkg::KIND_RANGE, '0, 1'b1);
        else walk_from(a);
      end
      default: ;
    endcase
  endfunction

  function void flag(string what, gdfw_pkg::res_t want, logic [gdfw_pkg::KIND_W-1:0] kind,
                     logic [gdfw_pkg::OUT_DATA_W-1:0] data, logic last);
    failures++;
    if (failures <= 10)
      $display({"mismatch (%s): expected kind %0d vertex %0d last %0d, ",
                "got kind %0d data %0d last %0d"},
               what, want.kind, want.vertex, want.last, kind, data, last);
  endfunction

  function void check_word(logic [gdfw_pkg::KIND_W-1:0] kind,
                           logic [gdfw_pkg::OUT_DATA_W-1:0] data, logic last);
    gdfw_pkg::res_t want;
    if (due_words.size() == 0) begin
      want = '0;
      flag("no word due", want, kind, data, last);
      return;
    end
    want = due_words.pop_front();
    if (kind !== want.kind) flag("kind", want, kind, data, last);
    else if (data !== gdfw_pkg::OUT_DATA_W'(want.vertex)) flag("vertex", want, kind, data, last);
    else if (last !== want.last) flag("last", want, kind, data, last);
  endfunction
endclass

module graph_depth_first_walk_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_COUNT  = 180;
  localparam logic [gdfw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [gdfw_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;  // first_vertex, second_vertex
  logic [gdfw_pkg::OP_W-1:0]       s_axis_tuser = '0;  // operation
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [gdfw_pkg::OUT_DATA_W-1:0] m_axis_tdata;       // vertex
  logic [gdfw_pkg::KIND_W-1:0]     m_axis_tuser;       // kind
  logic                            m_axis_tlast;

  graph_shadow shadow = new();
  bit          quiet = 1'b0;
  int          sent = 0;
  int          cycles = 0;
  int          hold_left = 0;

  graph_depth_first_walk DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL graph_depth_first_walk");
      $finish;
    end
  end

  // result side: check accepted words, stall in bursts
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    if (hold_left > 0) hold_left--;
    else if (!quiet && $urandom_range(0, 4) == 0) hold_left = $urandom_range(1, 3);
    m_axis_tready <= (hold_left == 0);
  end

  task automatic send_word(logic [gdfw_pkg::OP_W-1:0] op, logic [gdfw_pkg::VTX_W-1:0] a,
                           logic [gdfw_pkg::VTX_W-1:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, b, a};
    do @(posedge clk); while (!s_axis_tready);
    shadow.note_item(op, a, b);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic add_edge(logic [gdfw_pkg::VTX_W-1:0] a, logic [gdfw_pkg::VTX_W-1:0] b);
    send_word(gdfw_pkg::OP_ADD, a, b);
  endtask

  task automatic walk(logic [gdfw_pkg::VTX_W-1:0] a);
    send_word(gdfw_pkg::OP_WALK, a, gdfw_pkg::VTX_W'($urandom));
  endtask

  task automatic clear_graph();
    send_word(gdfw_pkg::OP_CLEAR, gdfw_pkg::VTX_W'($urandom), gdfw_pkg::VTX_W'($urandom));
  endtask

  // one clear, a build over a window of vertices, then walks with some noise
  task automatic build_and_walk(int n_edges, int lo, int span, int n_walks);
    clear_graph();
    for (int i = 0; i < n_edges; i++) begin
      case ($urandom_range(0, 9))
        0: send_word(OP_UNUSED, gdfw_pkg::VTX_W'($urandom), gdfw_pkg::VTX_W'($urandom));
        1: walk(gdfw_pkg::VTX_W'($urandom_range(lo, lo + span)));
        default: ;
      endcase
      add_edge(gdfw_pkg::VTX_W'($urandom_range(lo, lo + span)),
               gdfw_pkg::VTX_W'($urandom_range(lo, lo + span)));
    end
    for (int i = 0; i < n_walks; i++) begin
      if ($urandom_range(0, 5) == 0) walk(gdfw_pkg::VTX_W'($urandom));
      else walk(gdfw_pkg::VTX_W'($urandom_range(lo, lo + span)));
    end
  endtask

  initial begin
    int target;
    int lo;
    int span;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed
    clear_graph();
    add_edge(6'd0, 6'd63);
    add_edge(6'd63, 6'd62);
    add_edge(6'd5, 6'd5);              // self loop
    add_edge(6'd42, 6'd21);
    add_edge(6'd21, 6'd0);
    walk(6'd0);
    walk(6'd63);                       // start already visited
    walk(6'd5);
    send_word(OP_UNUSED, 6'd63, 6'd63); // unused code
    walk(6'd40);                       // isolated vertex
    add_edge(6'd1, 6'd2);
    add_edge(6'd2, 6'd3);
    walk(6'd3);
    clear_graph();
    walk(6'd63);
    walk(6'd0);

    // dense build that runs the edge pool full
    target = ITEM_COUNT;
    build_and_walk(131, 0, 15, 3);

    while (sent < target) begin
      if (sent > target - 30) quiet = 1'b1;
      span = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(3, 20);
      lo   = $urandom_range(0, 63 - span);
      build_and_walk($urandom_range(4, 24), lo, span, $urandom_range(2, 5));
    end
    s_axis_tvalid <= 1'b0;

    while (shadow.due_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (shadow.failures == 0 && shadow.due_words.size() == 0) begin
      $display("PASS graph_depth_first_walk");
    end else begin
      $display("FAIL graph_depth_first_walk");
    end
    $finish;
  end

endmodule

### graph_depth_first_walk.f
rtl/core/gdfw_pkg.sv
rtl/core/gdfw_ram.sv
rtl/core/gdfw_out_reg.sv
rtl/core/graph_depth_first_walk.sv
tb/graph_depth_first_walk_tb.sv
